>>> rtl/pslu_pkg.sv
// shared constants, widths and the arctangent table for the path segment and arc length unit
// no dependencies
package pslu_pkg;

	localparam int LINE_W = 17;
	localparam int ARC_W = 18;
	localparam int TD_OUT_W = ((LINE_W + ARC_W + 7) / 8) * 8;

	localparam logic [LINE_W-1:0] LINE_MAX = 17'h1FFFF;
	localparam logic [ARC_W-1:0] ARC_MAX = 18'h3FFFF;

	// q30 magnitudes up to and including 1.0
	localparam int Q30_W = 31;
	localparam int SQ_W = 61;
	localparam logic [SQ_W-1:0] ONE_Q60 = {1'b1, 60'd0};

	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_W = 36;
	localparam logic signed [CORDIC_W-1:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [CORDIC_W-1:0] TWO_PI_Q30 = 36'sd6746518852;

	// atan(2^-i) in q30
	function automatic logic [29:0] atan_q30(input int unsigned idx);
		logic [29:0] a;
		case (idx)
			0: a = 30'd843314857;
			1: a = 30'd497837829;
			2: a = 30'd263043837;
			3: a = 30'd133525159;
			4: a = 30'd67021687;
			5: a = 30'd33543516;
			6: a = 30'd16775851;
			7: a = 30'd8388437;
			8: a = 30'd4194283;
			9: a = 30'd2097149;
			default: a = 30'(31'd1 << (30 - idx));
		endcase
		return a;
	endfunction

endpackage

>>> rtl/pslu_isqrt.sv
// pipelined integer square root, one result bit per register stage
// standalone, side data travels alongside unchanged
module pslu_isqrt #(
	parameter int IN_W = 36,
	parameter int SIDE_W = 1,
	localparam int ROOT_W = (IN_W + 1) / 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   in_radicand,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output logic [SIDE_W-1:0] out_side
);
	localparam int RES_W = IN_W + 1;

	logic [ROOT_W-1:0] vld_s;
	logic [IN_W-1:0]   rad_s [ROOT_W];
	logic [RES_W-1:0]  res_s [ROOT_W];
	logic [SIDE_W-1:0] side_s [ROOT_W];
	logic [IN_W-1:0]   cur_rad [ROOT_W];
	logic [IN_W-1:0]   nxt_rad [ROOT_W];
	logic [RES_W-1:0]  cur_res [ROOT_W];
	logic [RES_W-1:0]  nxt_res [ROOT_W];

	always_comb begin
		logic [RES_W-1:0] trial;
		logic [RES_W-1:0] bitv;
		cur_rad[0] = in_radicand;
		cur_res[0] = '0;
		for (int k = 1; k < ROOT_W; k++) begin
			cur_rad[k] = rad_s[k-1];
			cur_res[k] = res_s[k-1];
		end
		for (int k = 0; k < ROOT_W; k++) begin
			bitv = RES_W'(1) << (2 * (ROOT_W - 1 - k));
			trial = cur_res[k] + bitv;
			if (RES_W'(cur_rad[k]) >= trial) begin
				nxt_rad[k] = cur_rad[k] - trial[IN_W-1:0];
				nxt_res[k] = (cur_res[k] >> 1) + bitv;
			end else begin
				nxt_rad[k] = cur_rad[k];
				nxt_res[k] = cur_res[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[ROOT_W-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int k = 1; k < ROOT_W; k++) begin
				side_s[k] <= side_s[k-1];
			end
			for (int k = 0; k < ROOT_W; k++) begin
				rad_s[k] <= nxt_rad[k];
				res_s[k] <= nxt_res[k];
			end
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign out_root  = res_s[ROOT_W-1][ROOT_W-1:0];
	assign out_side  = side_s[ROOT_W-1];

endmodule

>>> rtl/pslu_div.sv
// pipelined restoring fraction divider, one quotient bit per register stage
// standalone, requires dividend below divisor
module pslu_div #(
	parameter int RW = 32,
	parameter int STEPS = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RW-1:0]     in_rem,
	input  logic [RW-1:0]     in_div,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [STEPS-1:0]  out_q,
	output logic [SIDE_W-1:0] out_side
);
	logic [STEPS-1:0]  vld_s;
	logic [RW-1:0]     rem_s [STEPS];
	logic [RW-1:0]     div_s [STEPS];
	logic [STEPS-1:0]  q_s [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];
	logic [RW-1:0]     cur_rem [STEPS];
	logic [RW-1:0]     cur_div [STEPS];
	logic [STEPS-1:0]  cur_q [STEPS];
	logic [RW-1:0]     nxt_rem [STEPS];
	logic [STEPS-1:0]  nxt_q [STEPS];

	always_comb begin
		logic [RW:0] t;
		logic [RW:0] d;
		cur_rem[0] = in_rem;
		cur_div[0] = in_div;
		cur_q[0] = '0;
		for (int k = 1; k < STEPS; k++) begin
			cur_rem[k] = rem_s[k-1];
			cur_div[k] = div_s[k-1];
			cur_q[k] = q_s[k-1];
		end
		for (int k = 0; k < STEPS; k++) begin
			t = {cur_rem[k], 1'b0};
			d = t - {1'b0, cur_div[k]};
			if (t >= {1'b0, cur_div[k]}) begin
				nxt_rem[k] = d[RW-1:0];
				nxt_q[k] = {cur_q[k][STEPS-2:0], 1'b1};
			end else begin
				nxt_rem[k] = t[RW-1:0];
				nxt_q[k] = {cur_q[k][STEPS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[STEPS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int k = 1; k < STEPS; k++) begin
				side_s[k] <= side_s[k-1];
			end
			for (int k = 0; k < STEPS; k++) begin
				rem_s[k] <= nxt_rem[k];
				div_s[k] <= cur_div[k];
				q_s[k] <= nxt_q[k];
			end
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_q     = q_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

endmodule

>>> rtl/pslu_cordic.sv
// pipelined vectoring cordic, one rotation per register stage, angle out in q30
// depends on pslu_pkg for the arctangent table
module pslu_cordic #(
	parameter int SIDE_W = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [pslu_pkg::Q30_W-1:0]     in_x,
	input  logic [pslu_pkg::Q30_W-1:0]     in_y,
	input  logic [SIDE_W-1:0]              in_side,
	output logic                           out_valid,
	output logic signed [pslu_pkg::CORDIC_W-1:0] out_z,
	output logic [SIDE_W-1:0]              out_side
);
	import pslu_pkg::*;

	localparam int N = CORDIC_STEPS;
	localparam int ZW = CORDIC_W;

	logic [N-1:0]         vld_s;
	logic signed [ZW-1:0] x_s [N];
	logic signed [ZW-1:0] y_s [N];
	logic signed [ZW-1:0] z_s [N];
	logic [SIDE_W-1:0]    side_s [N];
	logic signed [ZW-1:0] cx [N];
	logic signed [ZW-1:0] cy [N];
	logic signed [ZW-1:0] cz [N];
	logic signed [ZW-1:0] nx [N];
	logic signed [ZW-1:0] ny [N];
	logic signed [ZW-1:0] nz [N];

	always_comb begin
		logic signed [ZW-1:0] xs;
		logic signed [ZW-1:0] ys;
		logic signed [ZW-1:0] at;
		cx[0] = $signed(ZW'(in_x));
		cy[0] = $signed(ZW'(in_y));
		cz[0] = '0;
		for (int k = 1; k < N; k++) begin
			cx[k] = x_s[k-1];
			cy[k] = y_s[k-1];
			cz[k] = z_s[k-1];
		end
		for (int k = 0; k < N; k++) begin
			// floor shifts
			xs = cx[k] >>> k;
			ys = cy[k] >>> k;
			at = $signed(ZW'(atan_q30(k)));
			if (!cy[k][ZW-1]) begin
				nx[k] = cx[k] + ys;
				ny[k] = cy[k] - xs;
				nz[k] = cz[k] + at;
			end else begin
				nx[k] = cx[k] - ys;
				ny[k] = cy[k] + xs;
				nz[k] = cz[k] - at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int k = 1; k < N; k++) begin
				side_s[k] <= side_s[k-1];
			end
			for (int k = 0; k < N; k++) begin
				x_s[k] <= nx[k];
				y_s[k] <= ny[k];
				z_s[k] <= nz[k];
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_z     = z_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

>>> rtl/path_segment_and_arc_length_unit.sv
// top level of the path segment and arc length unit: front end, acos, arc scaling
// depends on pslu_pkg, pslu_isqrt, pslu_div and pslu_cordic
//
// throughput: one item per cycle while the output register is not stalled; every stage is a plain register, no loops
// backpressure: a stalled output register freezes the whole pipeline in place
// reset: clears all valid bits and sets min_radius to 1
module path_segment_and_arc_length_unit #(
	parameter int COORD_WIDTH = 16,
	parameter int ANGLE_FRAC_BITS = 16,
	localparam int TD_IN_W = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [15:0]                     cfg_wdata,      // min_radius
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// start_x, start_y, end_x, end_y, center_x, center_y, radius, next_x, next_y
	input  logic [TD_IN_W-1:0]              s_axis_tdata,
	input  logic                            s_axis_tlast,   // is_last
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [pslu_pkg::TD_OUT_W-1:0]   m_axis_tdata    // line_length, arc_length
);
	import pslu_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int AFB = ANGLE_FRAC_BITS;
	// wide enough for any coordinate difference
	localparam int EW = 34;
	localparam int VW = (CW + 1 > 32) ? 32 : CW + 1;
	localparam int AW = (CW > 31) ? 31 : CW;
	localparam int PW = 2 * VW;
	localparam int DOTW = PW + 1;
	localparam int RW = 2 * AW;
	localparam int LSQ_W = 2 * LINE_W + 1;
	localparam int AFW = AFB + 4;
	localparam int PRW = AFW + AW;
	localparam logic signed [EW-1:0] LIM30 = 34'sd1073741824;

	typedef struct packed {
		logic          arc_zero;
		logic          r_pos;
		logic          crs_pos;
		logic          crs_neg;
		logic [AW-1:0] ar;
	} ctl_t;

	typedef struct packed {
		logic signed [DOTW-1:0] dot;
		logic [RW-1:0]          r2;
		ctl_t                   ctl;
		logic                   line_sat;
	} lside_t;

	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic              dot_neg;
		logic              sat;
		ctl_t              ctl;
	} dside_t;

	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic              neg_c;
		ctl_t              ctl;
		logic [Q30_W-1:0]  ax;
	} aside_t;

	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic              neg_c;
		ctl_t              ctl;
	} cside_t;

	function automatic logic signed [EW-1:0] fld(input logic [TD_IN_W-1:0] td,
			input int unsigned idx);
		return EW'($signed(td[idx*CW +: CW]));
	endfunction

	function automatic logic signed [VW-1:0] clamp_v(input logic signed [EW-1:0] d);
		logic signed [EW-1:0] c;
		if (d > LIM30) begin
			c = LIM30;
		end else if (d < -LIM30) begin
			c = -LIM30;
		end else begin
			c = d;
		end
		return c[VW-1:0];
	endfunction

	function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] d);
		return d[EW-1] ? $unsigned(-d) : $unsigned(d);
	endfunction

	// configuration register
	logic [15:0] min_radius_q;

	// global advance: the pipeline moves unless the output item is held
	logic en;

	// stage 1: differences, clamps, radius checks
	logic                   v_s1;
	logic [LINE_W-1:0]      ux_s1, uy_s1;
	logic                   lsat_s1;
	logic signed [VW-1:0]   v1x_s1, v1y_s1, v3x_s1, v3y_s1;
	logic [AW-1:0]          ar_s1;
	logic                   rpos_s1, az_s1;

	logic [EW-1:0]          ux_n, uy_n, mr_n;
	logic signed [EW-1:0]   ex_e, ey_e, cx_e, cy_e, r_e, nx_e, ny_e;

	// stage 2: products
	logic                   v_s2;
	logic [2*LINE_W-1:0]    ux2_s2, uy2_s2;
	logic signed [PW-1:0]   pxx_s2, pyy_s2, pxy_s2, pyx_s2;
	logic [RW-1:0]          r2_s2;
	logic                   lsat_s2, rpos_s2, az_s2;
	logic [AW-1:0]          ar_s2;

	// stage 3: sums
	logic                   v_s3;
	logic [LSQ_W-1:0]       lsq_s3;
	lside_t                 lsd_s3;
	logic signed [DOTW-1:0] crs_n;

	// line root
	logic                   l_valid;
	logic [LINE_W:0]        l_root;
	lside_t                 l_side;

	// stage 4, 5: cosine magnitude and saturation test
	logic                   v_s4, v_s5;
	logic [LINE_W-1:0]      line_s4;
	logic [DOTW-1:0]        ad_s4;
	logic                   dneg_s4;
	logic [RW-1:0]          r2_s4, r2_s5, rem_s5;
	ctl_t                   ctl_s4;
	dside_t                 dsd_s5;

	// divider
	logic                   d_valid;
	logic [AFB-1:0]         d_q;
	dside_t                 d_side;

	// stages 6 to 8: q30 cosine, its square, 1 - c^2
	logic                   v_s6, v_s7, v_s8;
	logic [AFB:0]           qf_n;
	logic [Q30_W-1:0]       ax_s6, ax_s7;
	cside_t                 cs_s6, cs_s7;
	logic [2*Q30_W-1:0]     sq_full;
	logic [SQ_W-1:0]        sq_s7, n_s8;
	aside_t                 as_s8;

	// acos root and cordic
	logic                   a_valid;
	logic [Q30_W-1:0]       a_root;
	aside_t                 a_side;
	logic                   c_valid;
	logic signed [CORDIC_W-1:0] c_z;
	cside_t                 c_side;
	cside_t                 cin_side;

	// stages 9 to 12: quadrant fix, rounding, scaling by radius
	logic                   v_s9, v_s10, v_s11, v_s12;
	logic signed [CORDIC_W-1:0] ang_s9;
	logic [CORDIC_W-2:0]    ang_s10;
	logic [AFW-1:0]         angf_s11, angf_n;
	logic [PRW-1:0]         prod_s12;
	cside_t                 cs_s9, cs_s10, cs_s11, cs_s12;
	logic signed [CORDIC_W-1:0] ang10_n;

	// output
	logic [PRW:0]           len_n;
	logic [ARC_W-1:0]       arc_n;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_radius_q <= 16'd1;
		end else if (cfg_we) begin
			min_radius_q <= cfg_wdata;
		end
	end

	// stage 1 logic
	always_comb begin
		logic signed [EW-1:0] sx_e, sy_e;
		sx_e = fld(s_axis_tdata, 0);
		sy_e = fld(s_axis_tdata, 1);
		ex_e = fld(s_axis_tdata, 2);
		ey_e = fld(s_axis_tdata, 3);
		cx_e = fld(s_axis_tdata, 4);
		cy_e = fld(s_axis_tdata, 5);
		r_e  = fld(s_axis_tdata, 6);
		nx_e = fld(s_axis_tdata, 7);
		ny_e = fld(s_axis_tdata, 8);
		ux_n = mag(ex_e - sx_e);
		uy_n = mag(ey_e - sy_e);
		mr_n = mag(r_e);
	end

	// stage 6 input: a saturated cosine becomes full scale, else the divider quotient
	always_comb begin
		qf_n = d_side.sat ? {1'b1, AFB'(0)} : {1'b0, d_q};
	end

	// angle rounding to the output fraction width
	generate
		if (AFB < 30) begin : g_round
			assign angf_n = AFW'((ang_s10 + ((CORDIC_W-1)'(1) << (29 - AFB))) >> (30 - AFB));
		end else begin : g_noround
			assign angf_n = AFW'(ang_s10);
		end
	endgenerate

	always_comb begin
		logic signed [CORDIC_W-1:0] t;
		logic flip;
		flip = cs_s9.ctl.r_pos ? cs_s9.ctl.crs_pos : cs_s9.ctl.crs_neg;
		t = flip ? (TWO_PI_Q30 - ang_s9) : ang_s9;
		ang10_n = t[CORDIC_W-1] ? '0 : t;
	end

	assign crs_n = DOTW'(pxy_s2) - DOTW'(pyx_s2);
	assign sq_full = ax_s6 * ax_s6;

	always_comb begin
		logic [PRW:0] half;
		half = (PRW + 1)'(1) << (AFB - 1);
		len_n = ((PRW + 1)'(prod_s12) + half) >> AFB;
		if (cs_s12.ctl.arc_zero) begin
			arc_n = '0;
		end else if (len_n > (PRW + 1)'(ARC_MAX)) begin
			arc_n = ARC_MAX;
		end else begin
			arc_n = len_n[ARC_W-1:0];
		end
	end

	// valid bits of the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= l_valid;
			v_s5 <= v_s4;
			v_s6 <= d_valid;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= c_valid;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			m_axis_tvalid <= v_s12;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			lsat_s1 <= (ux_n > EW'(LINE_MAX)) || (uy_n > EW'(LINE_MAX));
			ux_s1 <= ux_n[LINE_W-1:0];
			uy_s1 <= uy_n[LINE_W-1:0];
			v1x_s1 <= clamp_v(ex_e - cx_e);
			v1y_s1 <= clamp_v(ey_e - cy_e);
			v3x_s1 <= clamp_v(nx_e - cx_e);
			v3y_s1 <= clamp_v(ny_e - cy_e);
			ar_s1 <= (mr_n > EW'(LIM30)) ? AW'(LIM30) : AW'(mr_n);
			rpos_s1 <= !r_e[EW-1] && (r_e != '0);
			az_s1 <= s_axis_tlast || (mr_n < EW'(min_radius_q));

			// stage 2
			ux2_s2 <= ux_s1 * ux_s1;
			uy2_s2 <= uy_s1 * uy_s1;
			pxx_s2 <= v1x_s1 * v3x_s1;
			pyy_s2 <= v1y_s1 * v3y_s1;
			pxy_s2 <= v1x_s1 * v3y_s1;
			pyx_s2 <= v1y_s1 * v3x_s1;
			r2_s2 <= ar_s1 * ar_s1;
			lsat_s2 <= lsat_s1;
			rpos_s2 <= rpos_s1;
			az_s2 <= az_s1;
			ar_s2 <= ar_s1;

			// stage 3
			lsq_s3 <= LSQ_W'(ux2_s2) + LSQ_W'(uy2_s2);
			lsd_s3.dot <= DOTW'(pxx_s2) + DOTW'(pyy_s2);
			lsd_s3.r2 <= r2_s2;
			lsd_s3.line_sat <= lsat_s2;
			lsd_s3.ctl.arc_zero <= az_s2;
			lsd_s3.ctl.r_pos <= rpos_s2;
			lsd_s3.ctl.crs_pos <= !crs_n[DOTW-1] && (crs_n != '0);
			lsd_s3.ctl.crs_neg <= crs_n[DOTW-1];
			lsd_s3.ctl.ar <= ar_s2;

			// stage 4: line clip, |dot|
			if (l_side.line_sat || (l_root > (LINE_W + 1)'(LINE_MAX))) begin
				line_s4 <= LINE_MAX;
			end else begin
				line_s4 <= l_root[LINE_W-1:0];
			end
			ad_s4 <= l_side.dot[DOTW-1] ? $unsigned(-l_side.dot) : $unsigned(l_side.dot);
			dneg_s4 <= l_side.dot[DOTW-1];
			r2_s4 <= l_side.r2;
			ctl_s4 <= l_side.ctl;

			// stage 5: cosine saturates when |dot| reaches r^2
			dsd_s5.line <= line_s4;
			dsd_s5.dot_neg <= dneg_s4;
			dsd_s5.ctl <= ctl_s4;
			if (ad_s4 >= DOTW'(r2_s4)) begin
				dsd_s5.sat <= 1'b1;
				rem_s5 <= '0;
			end else begin
				dsd_s5.sat <= 1'b0;
				rem_s5 <= ad_s4[RW-1:0];
			end
			r2_s5 <= r2_s4;

			// stage 6: q30 cosine magnitude, sign only when nonzero
			ax_s6 <= Q30_W'(qf_n) << (30 - AFB);
			cs_s6.line <= d_side.line;
			cs_s6.neg_c <= d_side.dot_neg && (qf_n != '0);
			cs_s6.ctl <= d_side.ctl;

			// stage 7: c^2
			sq_s7 <= sq_full[SQ_W-1:0];
			ax_s7 <= ax_s6;
			cs_s7 <= cs_s6;

			// stage 8: 1 - c^2
			n_s8 <= ONE_Q60 - sq_s7;
			as_s8.line <= cs_s7.line;
			as_s8.neg_c <= cs_s7.neg_c;
			as_s8.ctl <= cs_s7.ctl;
			as_s8.ax <= ax_s7;

			// stage 9: negative cosine mirrors about pi/2
			ang_s9 <= c_side.neg_c ? (PI_Q30 - c_z) : c_z;
			cs_s9 <= c_side;

			// stage 10: long way round when turn direction disagrees
			ang_s10 <= ang10_n[CORDIC_W-2:0];
			cs_s10 <= cs_s9;

			// stage 11: round
			angf_s11 <= angf_n;
			cs_s11 <= cs_s10;

			// stage 12: scale by radius
			prod_s12 <= PRW'(angf_s11) * PRW'(cs_s11.ctl.ar);
			cs_s12 <= cs_s11;

			// output register
			m_axis_tdata <= TD_OUT_W'({arc_n, cs_s12.line});
		end
	end

	assign cin_side.line = a_side.line;
	assign cin_side.neg_c = a_side.neg_c;
	assign cin_side.ctl = a_side.ctl;

	pslu_isqrt #(
		.IN_W   (LSQ_W),
		.SIDE_W ($bits(lside_t))
	) u_line_root (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (v_s3),
		.in_radicand (lsq_s3),
		.in_side     (lsd_s3),
		.out_valid   (l_valid),
		.out_root    (l_root),
		.out_side    (l_side)
	);

	pslu_div #(
		.RW     (RW),
		.STEPS  (AFB),
		.SIDE_W ($bits(dside_t))
	) u_cos_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_rem    (rem_s5),
		.in_div    (r2_s5),
		.in_side   (dsd_s5),
		.out_valid (d_valid),
		.out_q     (d_q),
		.out_side  (d_side)
	);

	pslu_isqrt #(
		.IN_W   (SQ_W),
		.SIDE_W ($bits(aside_t))
	) u_sin_root (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (v_s8),
		.in_radicand (n_s8),
		.in_side     (as_s8),
		.out_valid   (a_valid),
		.out_root    (a_root),
		.out_side    (a_side)
	);

	pslu_cordic #(
		.SIDE_W ($bits(cside_t))
	) u_atan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (a_valid),
		.in_x      (a_side.ax),
		.in_y      (a_root),
		.in_side   (cin_side),
		.out_valid (c_valid),
		.out_z     (c_z),
		.out_side  (c_side)
	);

	// a forced-zero arc must leave as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s12 && cs_s12.ctl.arc_zero) |=> (m_axis_tdata[LINE_W +: ARC_W] == '0))
		else $error("arc length not zeroed");

	// saturated cosine enters the acos stage as full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && d_valid && d_side.sat) |=> (ax_s6 == (Q30_W'(1) << 30)))
		else $error("saturated cosine lost");

	// full-scale cosine squares to exactly one
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s6 && (ax_s6 == (Q30_W'(1) << 30))) |=> (sq_s7 == ONE_Q60))
		else $error("cosine square wrong at full scale");

	// oversized coordinate differences clip the line length
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && l_valid && l_side.line_sat) |=> (line_s4 == LINE_MAX))
		else $error("line length not saturated");

endmodule
